// ===== rtl/dqe_pkg.sv =====
// Package for the DNS query-name label encoder: payload structs, controller
// states, constants and the command/status bundles between controller and datapath.
// No dependencies.
package dqe_pkg;

  localparam int LABEL_CAPACITY = 62;
  localparam int MAX_RESULTS    = 64;
  // Label length used when a trailing dot follows a full label.
  localparam int TRUNC_LEN      = MAX_RESULTS - 3;
  localparam int CNT_W          = $clog2(LABEL_CAPACITY + 1);
  localparam int ADDR_W         = $clog2(LABEL_CAPACITY);

  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam logic [7:0] NUL_CHAR = 8'h00;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       label_overflow;
    logic       end_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_DATA,
    ST_EMPTY,
    ST_TERM
  } state_e;

  typedef struct packed {
    logic accept;      // take the input transaction
    logic load_len;    // emit the length byte
    logic load_data;   // emit the buffered character
    logic load_empty;  // emit the empty label after a trailing dot
    logic load_term;   // emit the zero terminator
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;   // output register can take a result this cycle
    logic emits;       // input item closes a label
    logic len_zero;    // closed label has no characters
    logic ptr_at_len;  // all characters of the label have been read
    logic extra_zero;  // trailing dot: empty label pending
    logic term;        // terminator pending
  } dp_sts_t;

endpackage

// ===== rtl/dns_qname_label_encoder_unit.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  in_item_t  {name_byte, is_final}
// out      output     out_valid_o/out_stall_i out_item_t {wire_byte, label_overflow, end_of_run}
//
// A character that closes no label is taken and gives no result. An item that closes
// a label is first taken, then gives its N results at one result per cycle as the
// controller loads the output register, while the output does not stall.
// Reset is asynchronous and clears control state only; the store needs no clearing.
// A stalled output holds the sequencer; input is taken again once the last result
// sits in the output register, even while that result waits.
// Top level: depends on dqe_pkg, dqe_ctrl, dqe_datapath.
module dns_qname_label_encoder_unit
  import dqe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  dp_cmd_t ctrl_cmd;
  dp_sts_t dp_sts;

  dqe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  dqe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts)
  );

endmodule

// ===== rtl/dqe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read data holds until the next read enable. No dependencies.
module dqe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dqe_datapath.sv =====
// Datapath of the label encoder: label store, fill count, overflow flag,
// read pointer and output register. Depends on dqe_pkg and dqe_ram.
module dqe_datapath
  import dqe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_seen_q, ovf_seen_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic             extra_q, extra_d;
  logic             term_q, term_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             is_dot, is_full, do_store, emits;
  logic             rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic             slot_free, len_zero, ptr_at_len;

  assign is_dot   = (in_data_i.name_byte == DOT_CHAR);
  assign is_full  = (count_q >= CNT_W'(LABEL_CAPACITY));
  assign do_store = cmd_i.accept && !is_dot && !is_full;
  assign emits    = is_dot || in_data_i.is_final;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign len_zero   = (len_q == '0);
  assign ptr_at_len = (ptr_q == len_q);

  assign rd_en   = (cmd_i.load_len && !len_zero) || (cmd_i.load_data && !ptr_at_len);
  assign rd_addr = cmd_i.load_len ? '0 : ptr_q[ADDR_W-1:0];

  dqe_ram #(
    .WIDTH (8),
    .DEPTH (LABEL_CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_store),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (in_data_i.name_byte),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Label bookkeeping on accept
  always_comb begin
    count_d    = count_q;
    ovf_seen_d = ovf_seen_q;
    len_d      = len_q;
    ovf_d      = ovf_q;
    extra_d    = extra_q;
    term_d     = term_q;
    if (cmd_i.accept) begin
      if (emits) begin
        count_d    = '0;
        ovf_seen_d = 1'b0;
        extra_d    = is_dot && in_data_i.is_final;
        term_d     = in_data_i.is_final;
        if (is_dot && in_data_i.is_final && (count_q > CNT_W'(TRUNC_LEN))) begin
          len_d = CNT_W'(TRUNC_LEN);
          ovf_d = 1'b1;
        end else begin
          len_d = do_store ? count_q + CNT_W'(1) : count_q;
          ovf_d = ovf_seen_q || (!is_dot && is_full);
        end
      end else if (do_store) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        ovf_seen_d = 1'b1;
      end
    end
  end

  // Read pointer: restart on accept, step with each issued read
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.accept) begin
      ptr_d = '0;
    end else if (rd_en) begin
      ptr_d = cmd_i.load_len ? CNT_W'(1) : ptr_q + CNT_W'(1);
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (cmd_i.load_len) begin
      out_valid_d          = 1'b1;
      out_d.wire_byte      = {{(8-CNT_W){1'b0}}, len_q};
      out_d.label_overflow = ovf_q;
      out_d.end_of_run     = len_zero && !term_q;
    end else if (cmd_i.load_data) begin
      out_valid_d          = 1'b1;
      out_d.wire_byte      = rd_data;
      out_d.label_overflow = ovf_q;
      out_d.end_of_run     = ptr_at_len && !term_q;
    end else if (cmd_i.load_empty) begin
      out_valid_d          = 1'b1;
      out_d.wire_byte      = NUL_CHAR;
      out_d.label_overflow = 1'b0;
      out_d.end_of_run     = 1'b0;
    end else if (cmd_i.load_term) begin
      out_valid_d          = 1'b1;
      out_d.wire_byte      = NUL_CHAR;
      out_d.label_overflow = 1'b0;
      out_d.end_of_run     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_seen_q  <= 1'b0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      extra_q     <= 1'b0;
      term_q      <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_seen_q  <= ovf_seen_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      extra_q     <= extra_d;
      term_q      <= term_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.slot_free  = slot_free;
  assign sts_o.emits      = emits;
  assign sts_o.len_zero   = len_zero;
  assign sts_o.ptr_at_len = ptr_at_len;
  assign sts_o.extra_zero = extra_q;
  assign sts_o.term       = term_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LABEL_CAPACITY))
    else $error("label count beyond capacity");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= len_q)
    else $error("read pointer beyond label length");

  a_data_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_data |-> (ptr_q != '0))
    else $error("character emitted without a preceding store read");

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_len || cmd_i.load_data || cmd_i.load_empty || cmd_i.load_term)
    |-> slot_free)
    else $error("output register overwritten while stalled");
`endif

endmodule

// ===== rtl/dqe_ctrl.sv =====
// Controller of the label encoder: sequences acceptance, length byte,
// characters, empty label and terminator. Depends on dqe_pkg.
module dqe_ctrl
  import dqe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  state_e after_label;

  // Where to go once the label's characters are out
  always_comb begin
    if (sts_i.extra_zero) begin
      after_label = ST_EMPTY;
    end else if (sts_i.term) begin
      after_label = ST_TERM;
    end else begin
      after_label = ST_IDLE;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && sts_i.emits) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (sts_i.slot_free) begin
          state_d = sts_i.len_zero ? after_label : ST_DATA;
        end
      end
      ST_DATA: begin
        if (sts_i.slot_free && sts_i.ptr_at_len) begin
          state_d = after_label;
        end
      end
      ST_EMPTY: begin
        if (sts_i.slot_free) begin
          state_d = ST_TERM;
        end
      end
      ST_TERM: begin
        if (sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_LEN:   cmd_o.load_len   = sts_i.slot_free;
      ST_DATA:  cmd_o.load_data  = sts_i.slot_free;
      ST_EMPTY: cmd_o.load_empty = sts_i.slot_free;
      ST_TERM:  cmd_o.load_term  = sts_i.slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.load_len, cmd_o.load_data,
              cmd_o.load_empty, cmd_o.load_term}))
    else $error("more than one datapath command at once");
`endif

endmodule

// ===== test/tb_dns_qname_label_encoder_unit.sv =====
`timescale 1ns / 100ps
// Testbench for dns_qname_label_encoder_unit: sends host-name bytes, predicts the
// DNS wire-form bytes and checks every output transaction against the prediction.
// Depends on dqe_pkg and the encoder RTL.
module tb_dns_qname_label_encoder_unit;
  import dqe_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 150;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  dns_qname_label_encoder_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Label buffer as the encoder should hold it
  logic [7:0]  lbl_chars [LABEL_CAPACITY];
  int unsigned lbl_len     = 0;
  logic        lbl_dropped = 1'b0;
  out_item_t   exp_wire_q[$];

  int err_count      = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_left      = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic void push_wire_byte(input logic [7:0] b, input logic ovf);
    out_item_t r;
    r.wire_byte      = b;
    r.label_overflow = ovf;
    r.end_of_run     = 1'b0;
    exp_wire_q.push_back(r);
  endfunction

  function automatic void predict_wire_bytes(input in_item_t it);
    logic        is_dot;
    int unsigned len;
    logic        ovf;
    int          first;
    is_dot = (it.name_byte == DOT_CHAR);
    first  = exp_wire_q.size();
    if (!is_dot) begin
      if (lbl_len < LABEL_CAPACITY) begin
        lbl_chars[lbl_len] = it.name_byte;
        lbl_len++;
      end else begin
        lbl_dropped = 1'b1;
      end
    end
    if (is_dot || it.is_final) begin
      len = lbl_len;
      ovf = lbl_dropped;
      // a trailing dot after a full label would overrun the result budget: cut it
      if (it.is_final && is_dot && len > TRUNC_LEN) begin
        len = TRUNC_LEN;
        ovf = 1'b1;
      end
      push_wire_byte(8'(len), ovf);
      for (int i = 0; i < len; i++) push_wire_byte(lbl_chars[i], ovf);
      lbl_len     = 0;
      lbl_dropped = 1'b0;
    end
    if (it.is_final) begin
      if (is_dot) push_wire_byte(8'h00, 1'b0);
      push_wire_byte(NUL_CHAR, 1'b0);
    end
    if (exp_wire_q.size() > first) exp_wire_q[exp_wire_q.size() - 1].end_of_run = 1'b1;
  endfunction

  // Monitor: predict on each input transaction, check each output transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_wire_bytes(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (exp_wire_q.size() == 0) begin
          report_mismatch("unexpected wire_byte", out_data_o.wire_byte, 0);
        end else begin
          if (out_data_o.wire_byte != exp_wire_q[0].wire_byte)
            report_mismatch("wire_byte", out_data_o.wire_byte, exp_wire_q[0].wire_byte);
          if (out_data_o.label_overflow != exp_wire_q[0].label_overflow)
            report_mismatch("label_overflow", out_data_o.label_overflow,
                            exp_wire_q[0].label_overflow);
          if (out_data_o.end_of_run != exp_wire_q[0].end_of_run)
            report_mismatch("end_of_run", out_data_o.end_of_run, exp_wire_q[0].end_of_run);
          void'(exp_wire_q.pop_front());
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_dns_qname_label_encoder_unit NOT OK");
        $finish;
      end
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_char(input logic [7:0] b, input logic fin);
    in_item_t it;
    it.name_byte = b;
    it.is_final  = fin;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    // stall is settled mid-cycle; a low stall there means the next edge takes it
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  task automatic send_name(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Pause input until every predicted byte has come out, then let the block settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (exp_wire_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == DOT_CHAR);
    return c;
  endfunction

  task automatic test_directed_names();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_name("a.b");
    send_name(".x");     // leading dot gives an empty label
    send_name("a..b");   // two dots in a row
    send_name("ab.");    // trailing dot leaves an empty label before the terminator
    send_name(".");
    send_char(8'h00, 1'b0);   // zero byte is an ordinary character
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_name("Z");
    drain_results();
  endtask

  task automatic test_label_capacity();
    // overrun the buffer, then close the full label with a final dot
    repeat (LABEL_CAPACITY + 1) send_char(rand_label_char(), 1'b0);
    send_char(DOT_CHAR, 1'b1);
    drain_results();
  endtask

  task automatic test_output_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = HOLD_CYCLES;
    send_name("ab.cd.ef");
    send_name("w.x.y.");
    drain_results();
  endtask

  task automatic send_random_name(output int n_sent);
    logic [7:0] name_q[$];
    int         n_labels;
    int         lbl_size;
    n_labels = $urandom_range(1, 4);
    for (int l = 0; l < n_labels; l++) begin
      case ($urandom_range(15))
        0:       lbl_size = 0;
        1:       lbl_size = $urandom_range(9, 40);
        default: lbl_size = $urandom_range(1, 8);
      endcase
      repeat (lbl_size) name_q.push_back(rand_label_char());
      if (l != n_labels - 1 || $urandom_range(3) == 0) name_q.push_back(DOT_CHAR);
    end
    if (name_q.size() == 0) name_q.push_back(rand_label_char());
    foreach (name_q[i]) send_char(name_q[i], i == name_q.size() - 1);
    n_sent = name_q.size();
  endtask

  task automatic test_random_names(input int n_items, input int idle_pct, input int stall_pct);
    int sent;
    int n;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < n_items) begin
      if ($urandom_range(4) == 0) begin
        // noise: stray bytes and dots, final flag at random
        if ($urandom_range(3) == 0) send_char(DOT_CHAR, $urandom_range(7) == 0);
        else send_char(8'($urandom_range(255)), $urandom_range(7) == 0);
        sent++;
      end else begin
        send_random_name(n);
        sent += n;
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_names();
    test_label_capacity();
    test_output_holdoff();
    test_random_names(8, 0, 0);
    test_random_names(8, 66, 0);
    test_random_names(8, 0, 66);
    test_random_names(8, 37, 37);
    if (exp_wire_q.size() != 0) report_mismatch("results missing", exp_wire_q.size(), 0);
    if (err_count == 0) begin
      $display("tb_dns_qname_label_encoder_unit OK");
    end else begin
      $display("tb_dns_qname_label_encoder_unit NOT OK");
    end
    $finish;
  end

endmodule
